// File: rtl/core/mnt_pkg.sv
// shared types, codes and the duration decoder of the note event slot tracker
// no dependencies; imported by mnt_slot_table, the top level and the testbench
package mnt_pkg;

	// message kinds on the result side
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ON   = 2'd1;
	localparam logic [1:0] KIND_OFF  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MAP_LOW  = 2'd0;
	localparam logic [1:0] REG_MAP_HIGH = 2'd1;
	localparam logic [1:0] REG_LOCK     = 2'd2;

	// register reset values
	localparam logic [63:0] MAP_LOW_RST  = 64'h0706050403020100;
	localparam logic [63:0] MAP_HIGH_RST = 64'h0F0E0D0C0B0A0908;

	// fixed bytes of an event ahead of the duration
	localparam logic [2:0] FIXED_BYTES = 3'd3;

	// one stored slot entry: logical channel and note
	typedef struct packed {
		logic [3:0] chan;
		logic [6:0] note;
	} slot_ent_t;

	// scan request from the sequencer
	typedef struct packed {
		logic       start;
		logic       rel;
		logic [3:0] chan;
		logic [6:0] note;
	} scan_req_t;

	// scan answer back to the sequencer
	typedef struct packed {
		logic done;
		logic hit;
	} scan_rsp_t;

	// slot write command
	typedef struct packed {
		logic        en;
		logic        rel;
		logic [3:0]  chan;
		logic [6:0]  note;
		logic [31:0] time_val;
	} slot_wr_t;

	// decoded variable-length duration
	typedef struct packed {
		logic [2:0]  nbytes;
		logic [27:0] value;
	} vlq_t;

	// stops at a clear top bit or after the fourth byte
	function automatic vlq_t vlq_decode(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3);
		vlq_t r;
		if (!b0[7]) begin
			r.nbytes = 3'd1;
			r.value  = {21'd0, b0[6:0]};
		end else if (!b1[7]) begin
			r.nbytes = 3'd2;
			r.value  = {14'd0, b0[6:0], b1[6:0]};
		end else if (!b2[7]) begin
			r.nbytes = 3'd3;
			r.value  = {7'd0, b0[6:0], b1[6:0], b2[6:0]};
		end else begin
			r.nbytes = 3'd4;
			r.value  = {b0[6:0], b1[6:0], b2[6:0], b3[6:0]};
		end
		return r;
	endfunction

endpackage

// File: rtl/core/mnt_slot_table.sv
// slot table: slot memory, occupancy bits and the shared scan compare unit
// depends on mnt_pkg
module mnt_slot_table #(
	parameter int SLOT_COUNT = 32,
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
	localparam int IW = $clog2(SLOT_COUNT + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mnt_pkg::scan_req_t req,
	output mnt_pkg::scan_rsp_t rsp,
	output logic [SW-1:0]      hit_idx,
	input  mnt_pkg::slot_wr_t  wr,
	input  logic [SW-1:0]      wr_idx
);
	import mnt_pkg::*;

	slot_ent_t           slot_mem [SLOT_COUNT];
	logic [31:0]         time_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] occ_q;

	logic          active_q;
	logic [IW-1:0] idx_q;
	logic          s1_vld_q;
	logic [SW-1:0] idx_s1;
	slot_ent_t     rd_s1;
	logic          rd_en;
	logic          cmp_hit;
	logic          cmp_last;

	// one read per cycle while the scan is live
	assign rd_en = active_q && (idx_q < IW'(SLOT_COUNT)) && !rsp.done;

	// compare unit on the registered read beat
	always_comb begin
		if (req.rel) begin
			cmp_hit = occ_q[idx_s1] && (rd_s1.chan == req.chan) && (rd_s1.note == req.note);
		end else begin
			cmp_hit = !occ_q[idx_s1];
		end
		cmp_last = (idx_s1 == SW'(SLOT_COUNT - 1));
	end

	assign rsp.hit  = active_q && s1_vld_q && cmp_hit;
	assign rsp.done = active_q && s1_vld_q && (cmp_hit || cmp_last);
	assign hit_idx  = idx_s1;

	// scan sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			s1_vld_q <= 1'b0;
		end else if (req.start) begin
			active_q <= 1'b1;
			idx_q    <= '0;
			s1_vld_q <= 1'b0;
		end else if (rsp.done) begin
			active_q <= 1'b0;
			s1_vld_q <= 1'b0;
		end else begin
			s1_vld_q <= rd_en;
			if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// occupancy bits, all free after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (wr.en) begin
			occ_q[wr_idx] <= !wr.rel;
		end
	end

	// slot memories, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1  <= slot_mem[idx_q[SW-1:0]];
			idx_s1 <= idx_q[SW-1:0];
		end
		if (wr.en && !wr.rel) begin
			slot_mem[wr_idx] <= '{chan: wr.chan, note: wr.note};
			time_mem[wr_idx] <= wr.time_val;
		end
	end

endmodule

// File: rtl/core/midi_note_event_slot_tracker_top.sv
// note event slot tracker: duration decode, slot scan sequencer, channel counters
// depends on mnt_pkg and mnt_slot_table
// for a locked channel done follows start in the next cycle; otherwise the slot table reads
// the slots in order into its registered read beat, and done is registered once a slot answers
// the search or the last slot is compared; busy stays high while the slot scan runs, one slot per
// cycle; no event is taken while busy; done is a one-cycle strobe and the receiver cannot stall it
// reset: all slots free, held and per-channel counters zero, registers at their defaults
module midi_note_event_slot_tracker_top #(
	parameter int SLOT_COUNT = 32,
	parameter int PHYS_CHANNELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [7:0]  status_byte,
	input  logic [6:0]  note_number,
	input  logic [6:0]  velocity_in,
	input  logic [7:0]  dur_byte0,
	input  logic [7:0]  dur_byte1,
	input  logic [7:0]  dur_byte2,
	input  logic [7:0]  dur_byte3,
	output logic        done,
	output logic [2:0]  event_length,
	output logic [1:0]  message_kind,
	output logic [7:0]  out_channel,
	output logic [6:0]  out_note,
	output logic [6:0]  out_velocity,
	output logic [5:0]  held_notes
);
	import mnt_pkg::*;

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PW = (PHYS_CHANNELS > 1) ? $clog2(PHYS_CHANNELS) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;

	logic [63:0] map_lo_q;
	logic [63:0] map_hi_q;
	logic [15:0] lock_q;

	logic [3:0]  chan_q;
	logic [6:0]  note_q;
	logic [6:0]  vel_q;
	logic [7:0]  phys_q;
	logic [31:0] dur_q;
	logic [2:0]  len_q;
	logic [5:0]  held_q;

	logic [7:0]  cnt_mem [PHYS_CHANNELS];
	logic [PHYS_CHANNELS-1:0] cnt_vld_q;
	logic [7:0]  cnt_rd_q;
	logic [7:0]  cnt_cur;
	logic [PW-1:0] cnt_addr;
	logic        phys_ok;

	logic        accept;
	logic        locked;
	logic [63:0] map_word;
	logic [7:0]  phys_in;
	vlq_t        vlq;

	scan_req_t   sreq;
	scan_rsp_t   srsp;
	slot_wr_t    swr;
	logic [SW-1:0] hit_idx;
	logic [SW-1:0] wr_idx;
	logic        finish;

	logic        done_q;
	logic [2:0]  len_out_q;
	logic [1:0]  kind_q;
	logic [7:0]  och_q;
	logic [6:0]  onote_q;
	logic [6:0]  ovel_q;

	// input decode
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign locked   = lock_q[status_byte[3:0]];
	assign map_word = status_byte[3] ? map_hi_q : map_lo_q;
	assign phys_in  = map_word[{status_byte[2:0], 3'b000} +: 8];
	assign vlq      = vlq_decode(dur_byte0, dur_byte1, dur_byte2, dur_byte3);

	// channel counter addressing
	assign phys_ok  = ({1'b0, phys_q} < 9'(PHYS_CHANNELS));
	assign cnt_addr = phys_q[PW-1:0];
	assign cnt_cur  = cnt_vld_q[cnt_addr] ? cnt_rd_q : 8'd0;

	// scan request and slot write
	assign finish        = (state_q == ST_SCAN) && srsp.done;
	assign sreq.start    = accept && !locked;
	assign sreq.rel      = (vel_q == 7'd0);
	assign sreq.chan     = chan_q;
	assign sreq.note     = note_q;
	assign swr.en        = finish && ((vel_q != 7'd0) || srsp.hit);
	assign swr.rel       = (vel_q == 7'd0);
	assign swr.chan      = chan_q;
	assign swr.note      = note_q;
	assign swr.time_val  = dur_q;
	assign wr_idx        = srsp.hit ? hit_idx : '0;

	mnt_slot_table #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (sreq),
		.rsp     (srsp),
		.hit_idx (hit_idx),
		.wr      (swr),
		.wr_idx  (wr_idx)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_lo_q <= MAP_LOW_RST;
			map_hi_q <= MAP_HIGH_RST;
			lock_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAP_LOW:  map_lo_q <= cfg_data;
				REG_MAP_HIGH: map_hi_q <= cfg_data;
				REG_LOCK:     lock_q   <= cfg_data[15:0];
				default:      ;
			endcase
		end
	end

	// event capture
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q <= status_byte[3:0];
			note_q <= note_number;
			vel_q  <= velocity_in;
			phys_q <= phys_in;
			dur_q  <= {4'd0, vlq.value} - 32'd1;
			len_q  <= FIXED_BYTES + vlq.nbytes;
		end
	end

	// sequencer, held count and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (locked) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (srsp.done) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						if (srsp.hit) begin
							held_q <= (vel_q == 7'd0) ? held_q - 6'd1 : held_q + 6'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && locked) begin
			len_out_q <= FIXED_BYTES + vlq.nbytes;
			kind_q    <= KIND_NONE;
			och_q     <= 8'd0;
			onote_q   <= 7'd0;
			ovel_q    <= 7'd0;
		end else if (finish) begin
			len_out_q <= len_q;
			if (swr.en) begin
				kind_q  <= (vel_q == 7'd0) ? KIND_OFF : KIND_ON;
				och_q   <= phys_q;
				onote_q <= note_q;
				ovel_q  <= vel_q;
			end else begin
				kind_q  <= KIND_NONE;
				och_q   <= 8'd0;
				onote_q <= 7'd0;
				ovel_q  <= 7'd0;
			end
		end
	end

	// per-channel counters: read during the scan, written when it ends
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && phys_ok) begin
			cnt_rd_q <= cnt_mem[cnt_addr];
		end
		if (swr.en && phys_ok) begin
			cnt_mem[cnt_addr] <= swr.rel ? cnt_cur - 8'd1 : cnt_cur + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
		end else if (swr.en && phys_ok) begin
			cnt_vld_q[cnt_addr] <= 1'b1;
		end
	end

	assign done         = done_q;
	assign event_length = len_out_q;
	assign message_kind = kind_q;
	assign out_channel  = och_q;
	assign out_note     = onote_q;
	assign out_velocity = ovel_q;
	assign held_notes   = held_q;

	// a result beat never comes while a scan is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat during a scan");

	// an accepted event either finishes at once or starts a scan
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted event went nowhere");

	// a beat with nothing sent carries zero message fields
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (message_kind == KIND_NONE)) |->
		((out_channel == 8'd0) && (out_note == 7'd0) && (out_velocity == 7'd0)))
		else $error("empty beat with message fields set");

	// a note-off always carries zero velocity
	a_off_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (message_kind == KIND_OFF)) |-> (out_velocity == 7'd0))
		else $error("note-off with nonzero velocity");

endmodule

// File: dv/testbench.sv
// self-checking testbench for the note event slot tracker: directed table, then random phases
// depends on mnt_pkg and midi_note_event_slot_tracker_top; predicts every result beat
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mnt_pkg::*;

	localparam int SLOTS        = 32;
	localparam int ITEM_BUDGET  = 1650;
	localparam int PHASE_ITEMS  = 150;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 40;

	// one note event as presented on the input ports
	typedef struct packed {
		logic [7:0] status;
		logic [6:0] note;
		logic [6:0] vel;
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] d2;
		logic [7:0] d3;
	} note_ev_t;

	// one result beat
	typedef struct packed {
		logic [2:0] len;
		logic [1:0] kind;
		logic [7:0] chan;
		logic [6:0] note;
		logic [6:0] vel;
		logic [5:0] held;
	} note_msg_t;

	// directed rows: plain event, event with a typed expectation, register write
	typedef enum logic [1:0] {ROW_EV, ROW_CHK, ROW_CFG} row_op_t;

	typedef struct packed {
		row_op_t     op;
		logic [1:0]  idx;
		logic [63:0] val;
		logic [7:0]  status;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [7:0]  d0;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic [7:0]  d3;
		logic [2:0]  e_len;
		logic [1:0]  e_kind;
		logic [7:0]  e_chan;
		logic [6:0]  e_note;
		logic [6:0]  e_vel;
		logic [5:0]  e_held;
	} stim_row_t;

	localparam int DIR_ROWS = 26;

	stim_row_t dir_tbl [DIR_ROWS] = '{
		// release on an empty table sends nothing
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h90, 7'd60, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd4, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h90, 7'd60, 7'd100, 8'h05, 8'h00, 8'h00, 8'h00,
			3'd4, KIND_ON, 8'd0, 7'd60, 7'd100, 6'd1},
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h80, 7'd60, 7'd0, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
			3'd4, KIND_OFF, 8'd0, 7'd60, 7'd0, 6'd0},
		// top note and velocity, three duration bytes
		'{ROW_CHK, REG_LOCK, 64'd0, 8'hFF, 7'd127, 7'd127, 8'h81, 8'h80, 8'h00, 8'hFF,
			3'd6, KIND_ON, 8'd15, 7'd127, 7'd127, 6'd1},
		// four continuing bytes stop after the fourth
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h8E, 7'd0, 7'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			3'd7, KIND_ON, 8'd14, 7'd0, 7'd1, 6'd2},
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h0F, 7'd127, 7'd0, 8'h80, 8'h00, 8'hFF, 8'hFF,
			3'd5, KIND_OFF, 8'd15, 7'd127, 7'd0, 6'd1},
		// zero duration, then the same channel and note twice, released one by one
		'{ROW_EV, REG_LOCK, 64'd0, 8'h93, 7'd5, 7'd64, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_EV, REG_LOCK, 64'd0, 8'h93, 7'd5, 7'd64, 8'h81, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_EV, REG_LOCK, 64'd0, 8'h93, 7'd5, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_EV, REG_LOCK, 64'd0, 8'h93, 7'd5, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_EV, REG_LOCK, 64'd0, 8'h93, 7'd5, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_EV, REG_LOCK, 64'd0, 8'hA4, 7'd5, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		// locked channel reports only the length
		'{ROW_CFG, REG_LOCK, 64'h1, 8'h00, 7'd0, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h90, 7'd60, 7'd100, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd4, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd1},
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h90, 7'd60, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd4, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd1},
		// unmapped physical channels still carry the message
		'{ROW_CFG, REG_LOCK, 64'h8000, 8'h00, 7'd0, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_CFG, REG_MAP_LOW, 64'hFFFF_FFFF_FFFF_FF10, 8'h00, 7'd0, 7'd0, 8'h00, 8'h00,
			8'h00, 8'h00, 3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h90, 7'd60, 7'd100, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd4, KIND_ON, 8'h10, 7'd60, 7'd100, 6'd2},
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h91, 7'd61, 7'd127, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd4, KIND_ON, 8'hFF, 7'd61, 7'd127, 6'd3},
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h90, 7'd60, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd4, KIND_OFF, 8'h10, 7'd60, 7'd0, 6'd2},
		'{ROW_CHK, REG_LOCK, 64'd0, 8'h9F, 7'd60, 7'd50, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd4, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd2},
		'{ROW_CFG, REG_MAP_HIGH, 64'd0, 8'h00, 7'd0, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_CFG, REG_LOCK, 64'd0, 8'h00, 7'd0, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_CFG, REG_MAP_LOW, MAP_LOW_RST, 8'h00, 7'd0, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_EV, REG_LOCK, 64'd0, 8'h8E, 7'd0, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0},
		'{ROW_EV, REG_LOCK, 64'd0, 8'h9A, 7'd33, 7'd90, 8'hFF, 8'h80, 8'h80, 8'h7F,
			3'd0, KIND_NONE, 8'd0, 7'd0, 7'd0, 6'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_MAP_LOW;
	logic [63:0] cfg_data = 64'd0;
	logic [7:0]  status_byte = 8'd0;
	logic [6:0]  note_number = 7'd0;
	logic [6:0]  velocity_in = 7'd0;
	logic [7:0]  dur_byte0 = 8'd0;
	logic [7:0]  dur_byte1 = 8'd0;
	logic [7:0]  dur_byte2 = 8'd0;
	logic [7:0]  dur_byte3 = 8'd0;
	logic        done;
	logic [2:0]  event_length;
	logic [1:0]  message_kind;
	logic [7:0]  out_channel;
	logic [6:0]  out_note;
	logic [6:0]  out_velocity;
	logic [5:0]  held_notes;

	// mirror of the slot table and registers
	logic [7:0]  tbl_chan [SLOTS];
	logic [6:0]  tbl_note [SLOTS];
	logic [5:0]  held_cnt;
	logic [63:0] map_lo;
	logic [63:0] map_hi;
	logic [15:0] lock_bits;

	note_msg_t pending_msgs [$];
	int        fail_count = 0;

	midi_note_event_slot_tracker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.status_byte  (status_byte),
		.note_number  (note_number),
		.velocity_in  (velocity_in),
		.dur_byte0    (dur_byte0),
		.dur_byte1    (dur_byte1),
		.dur_byte2    (dur_byte2),
		.dur_byte3    (dur_byte3),
		.done         (done),
		.event_length (event_length),
		.message_kind (message_kind),
		.out_channel  (out_channel),
		.out_note     (out_note),
		.out_velocity (out_velocity),
		.held_notes   (held_notes)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// next message for one event, updating the mirrored slot table
	function automatic note_msg_t predict_note_event(input note_ev_t ev);
		note_msg_t   msg;
		logic [3:0]  chan;
		logic [63:0] word;
		logic [7:0]  phys;
		int          nbytes;
		int          slot;
		bit          hit;
		chan = ev.status[3:0];
		if (!ev.d0[7])
			nbytes = 1;
		else if (!ev.d1[7])
			nbytes = 2;
		else if (!ev.d2[7])
			nbytes = 3;
		else
			nbytes = 4;
		msg = '0;
		msg.len = 3'(3 + nbytes);
		if (!lock_bits[chan]) begin
			word = chan[3] ? map_hi : map_lo;
			phys = word[chan[2:0]*8 +: 8];
			if (ev.vel == 7'd0) begin
				// release frees the first slot holding this channel and note
				hit = 1'b0;
				for (int i = 0; i < SLOTS && !hit; i++) begin
					if (tbl_chan[i] == {4'h0, chan} && tbl_note[i] == ev.note) begin
						hit = 1'b1;
						tbl_chan[i] = 8'hFF;
						held_cnt = held_cnt - 6'd1;
						msg.kind = KIND_OFF;
						msg.chan = phys;
						msg.note = ev.note;
					end
				end
			end else begin
				// first free slot, or slot 0 overwritten when the table is full
				slot = -1;
				for (int i = 0; i < SLOTS && slot < 0; i++)
					if (tbl_chan[i] == 8'hFF)
						slot = i;
				if (slot < 0)
					slot = 0;
				else
					held_cnt = held_cnt + 6'd1;
				tbl_chan[slot] = {4'h0, chan};
				tbl_note[slot] = ev.note;
				msg.kind = KIND_ON;
				msg.chan = phys;
				msg.note = ev.note;
				msg.vel  = ev.vel;
			end
		end
		msg.held = held_cnt;
		return msg;
	endfunction

	// present one event beat after a gap and wait for it to be taken
	task automatic issue_event(input note_ev_t ev, input int gap, input bit typed,
		input note_msg_t typed_msg);
		note_msg_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		status_byte <= ev.status;
		note_number <= ev.note;
		velocity_in <= ev.vel;
		dur_byte0   <= ev.d0;
		dur_byte1   <= ev.d1;
		dur_byte2   <= ev.d2;
		dur_byte3   <= ev.d3;
		start       <= 1'b1;
		do @(negedge clk); while (busy);
		@(posedge clk);
		predicted = predict_note_event(ev);
		pending_msgs.push_back(typed ? typed_msg : predicted);
	endtask

	// drop start and wait until every result beat has come back
	task automatic wait_tracker_idle();
		start <= 1'b0;
		do @(negedge clk); while (pending_msgs.size() != 0 || busy);
		@(posedge clk);
	endtask

	// single register write, mirrored into the predictor
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_MAP_LOW:  map_lo = val;
			REG_MAP_HIGH: map_hi = val;
			REG_LOCK:     lock_bits = val[15:0];
			default:      ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_map(input logic [63:0] rst_val);
		logic [63:0] m;
		case ($urandom_range(0, 4))
			0: m = rst_val;
			1: m = '0;
			2: m = '1;
			3: m = {$urandom, $urandom};
			default: begin
				for (int b = 0; b < 8; b++)
					m[b*8 +: 8] = 8'($urandom_range(0, 15));
			end
		endcase
		return m;
	endfunction

	// note-ons at the given share, otherwise mostly releases of held notes, some stray releases
	task automatic make_random_event(input int on_pct, output note_ev_t ev);
		int         roll;
		int         nbytes;
		int         pick;
		int         held_idx [$];
		logic [3:0] chan;
		logic [7:0] b [4];
		roll = $urandom_range(0, 99);
		chan = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 2) == 0)
			ev.note = $urandom_range(0, 1) ? 7'($urandom_range(0, 3)) :
				7'($urandom_range(124, 127));
		else
			ev.note = 7'($urandom_range(0, 127));
		if (roll < on_pct) begin
			case ($urandom_range(0, 9))
				0: ev.vel = 7'd127;
				1: ev.vel = 7'd1;
				default: ev.vel = 7'($urandom_range(1, 127));
			endcase
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (tbl_chan[i] != 8'hFF)
					held_idx.push_back(i);
			if (held_idx.size() > 0 && roll < on_pct + (100 - on_pct) * 4 / 5) begin
				pick = held_idx[$urandom_range(0, held_idx.size() - 1)];
				chan = tbl_chan[pick][3:0];
				ev.note = tbl_note[pick];
			end
			ev.vel = 7'd0;
		end
		ev.status = {4'($urandom_range(0, 15)), chan};
		// duration of 1..4 bytes, sometimes raw bytes
		nbytes = $urandom_range(1, 4);
		for (int k = 0; k < 4; k++)
			b[k] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) != 0) begin
			for (int k = 0; k < 4; k++) begin
				if (k < nbytes - 1)
					b[k][7] = 1'b1;
				else if (k == nbytes - 1 && nbytes < 4)
					b[k][7] = 1'b0;
			end
		end
		ev.d0 = b[0];
		ev.d1 = b[1];
		ev.d2 = b[2];
		ev.d3 = b[3];
	endtask

	// result beat checker
	always @(negedge clk) begin
		note_msg_t seen;
		note_msg_t want;
		if (arst_n && done) begin
			seen = {event_length, message_kind, out_channel, out_note, out_velocity,
				held_notes};
			if (pending_msgs.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("unexpected result beat: len %0d kind %0d ch %0d note %0d",
						seen.len, seen.kind, seen.chan, seen.note);
				fail_count++;
			end else begin
				want = pending_msgs.pop_front();
				if (seen.len !== want.len || seen.kind !== want.kind ||
					seen.chan !== want.chan || seen.note !== want.note ||
					seen.vel !== want.vel || seen.held !== want.held) begin
					if (fail_count < MAX_REPORTS)
						$display({"mismatch exp/got: len %0d/%0d kind %0d/%0d ch %0d/%0d ",
							"note %0d/%0d vel %0d/%0d held %0d/%0d"},
							want.len, seen.len, want.kind, seen.kind, want.chan, seen.chan,
							want.note, seen.note, want.vel, seen.vel, want.held, seen.held);
					fail_count++;
				end
			end
		end
	end

	// main sequence
	initial begin
		note_ev_t  ev;
		note_msg_t row_msg;
		int        counted;
		int        in_phase;
		int        phase;
		int        on_pct;
		int        item_no;
		int        gap;
		bit        idle_on;
		logic [63:0] lo_val;
		logic [63:0] hi_val;
		logic [15:0] lock_val;

		for (int i = 0; i < SLOTS; i++) begin
			tbl_chan[i] = 8'hFF;
			tbl_note[i] = 7'd0;
		end
		held_cnt  = 6'd0;
		map_lo    = MAP_LOW_RST;
		map_hi    = MAP_HIGH_RST;
		lock_bits = 16'd0;
		idle_on   = 1'b1;
		item_no   = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_tbl[r]) begin
			if (dir_tbl[r].op == ROW_CFG) begin
				wait_tracker_idle();
				write_reg(dir_tbl[r].idx, dir_tbl[r].val);
			end else begin
				ev = {dir_tbl[r].status, dir_tbl[r].note, dir_tbl[r].vel, dir_tbl[r].d0,
					dir_tbl[r].d1, dir_tbl[r].d2, dir_tbl[r].d3};
				row_msg = {dir_tbl[r].e_len, dir_tbl[r].e_kind, dir_tbl[r].e_chan,
					dir_tbl[r].e_note, dir_tbl[r].e_vel, dir_tbl[r].e_held};
				gap = $urandom_range(0, 13);
				issue_event(ev, gap, dir_tbl[r].op == ROW_CHK, row_msg);
			end
		end

		// random phases, each under its own register setting
		counted = 0;
		phase   = 0;
		while (counted < ITEM_BUDGET) begin
			case (phase)
				0: begin
					lo_val = '0;
					hi_val = '0;
					lock_val = 16'h0000;
				end
				1: begin
					lo_val = '1;
					hi_val = '1;
					lock_val = 16'hFFFF;
				end
				2: begin
					lo_val = MAP_LOW_RST;
					hi_val = MAP_HIGH_RST;
					lock_val = 16'h0000;
				end
				default: begin
					lo_val = rand_map(MAP_LOW_RST);
					hi_val = rand_map(MAP_HIGH_RST);
					case ($urandom_range(0, 5))
						0, 1, 2: lock_val = 16'h0000;
						3: lock_val = 16'($urandom) & 16'($urandom);
						4: lock_val = 16'($urandom);
						default: lock_val = 16'hFFFF;
					endcase
				end
			endcase
			wait_tracker_idle();
			write_reg(REG_MAP_LOW, lo_val);
			write_reg(REG_MAP_HIGH, hi_val);
			write_reg(REG_LOCK, {48'd0, lock_val});
			case ($urandom_range(0, 2))
				0: on_pct = 30;
				1: on_pct = 55;
				default: on_pct = 80;
			endcase
			in_phase = 0;
			while (in_phase < PHASE_ITEMS && counted < ITEM_BUDGET) begin
				make_random_event(on_pct, ev);
				in_phase++;
				counted++;
				if (item_no % 64 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				item_no++;
				gap = idle_on ? $urandom_range(0, 13) : 0;
				issue_event(ev, gap, 1'b0, '0);
			end
			phase++;
		end

		// drain and finish
		wait_tracker_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_msgs.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/mnt_pkg.sv
rtl/core/mnt_slot_table.sv
rtl/core/midi_note_event_slot_tracker_top.sv
dv/testbench.sv
